// File: hdl/ssi_pkg.sv
// shared types and constants for the sorted set insert block
package ssi_pkg;

  localparam int unsigned DATA_W           = 32;
  localparam int unsigned STATUS_W         = 2;
  localparam int unsigned FIELD_W          = 7;
  localparam int unsigned DEFAULT_CAPACITY = 64;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 2'd0,
    ST_PRESENT  = 2'd1,
    ST_FULL     = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_SCAN,
    S_WRITE
  } ssi_state_e;

  typedef struct packed {
    logic load;   // capture compare flags into the cell
    logic shift;  // move scan flags one cell towards the head
    logic write;  // insert shift of the stored values
  } ssi_ctrl_t;

endpackage

// File: hdl/ssi_cell.sv
// one storage cell of the sorted chain: value, compare flags and scan flags
module ssi_cell import ssi_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ssi_ctrl_t                ctrl_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic                     valid_i,
  input  logic signed [DATA_W-1:0] left_val_i,
  input  logic                     left_lt_i,
  input  logic                     scan_lt_i,
  input  logic                     scan_eq_i,
  output logic signed [DATA_W-1:0] val_o,
  output logic                     lt_o,
  output logic                     scan_lt_o,
  output logic                     scan_eq_o
);

  logic signed [DATA_W-1:0] val_q;
  logic                     lt_q;
  logic                     scan_lt_q;
  logic                     scan_eq_q;
  logic                     cmp_lt;
  logic                     cmp_eq;

  // stored entry is below the incoming value
  assign cmp_lt = valid_i && (val_q < value_i);
  assign cmp_eq = valid_i && (val_q == value_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lt_q      <= 1'b0;
      scan_lt_q <= 1'b0;
      scan_eq_q <= 1'b0;
    end else if (ctrl_i.load) begin
      lt_q      <= cmp_lt;
      scan_lt_q <= cmp_lt;
      scan_eq_q <= cmp_eq;
    end else if (ctrl_i.shift) begin
      scan_lt_q <= scan_lt_i;
      scan_eq_q <= scan_eq_i;
    end
  end

  // entries at or above the slot take the left neighbour, the slot takes the value
  always_ff @(posedge clk_i) begin
    if (ctrl_i.write && !lt_q) begin
      if (left_lt_i) begin
        val_q <= value_i;
      end else begin
        val_q <= left_val_i;
      end
    end
  end

  assign val_o     = val_q;
  assign lt_o      = lt_q;
  assign scan_lt_o = scan_lt_q;
  assign scan_eq_o = scan_eq_q;

endmodule

// File: hdl/sorted_set_insert_top.sv
// top level of the sorted set insert block: cell chain and sequencer
//
// Keeps up to CAPACITY distinct signed 32-bit values in ascending order in a
// row of cells. A transfer into the block happens on a rising edge with
// start_i high and busy_o low; value_i is taken then. One result follows
// each transfer: valid_o is high for exactly one cycle with status_o,
// position_o and count_o, and the result is taken at the end of that cycle.
// The receiver cannot stall the block, so no result is ever held back.
// Sequence: after the transfer the S_CMP state compares the value against
// every cell at once, then in S_SCAN the compare flags shift towards the head
// of the chain one cell a cycle until the first entry not below the value is
// seen. A new value then passes through S_WRITE for the shift of the stored
// entries. The strobe is registered from the state that decides: S_SCAN for
// present or full, S_WRITE for an insertion, and busy_o is low again in the
// strobe cycle.
// Reset empties the set (count zero) at once; no clearing pass is needed.
module sorted_set_insert_top import ssi_pkg::*; #(
  parameter int unsigned CAPACITY = DEFAULT_CAPACITY
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [DATA_W-1:0] value_i,
  output logic                     busy_o,
  output logic                     valid_o,
  output logic [STATUS_W-1:0]      status_o,
  output logic [FIELD_W-1:0]       position_o,
  output logic [FIELD_W-1:0]       count_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  ssi_state_e               state_q, state_d;
  ssi_ctrl_t                ctrl;
  logic signed [DATA_W-1:0] value_q;
  logic [CW-1:0]            count_q, count_d;
  logic [CW-1:0]            k_q, k_d;
  logic                     valid_q, valid_d;
  status_e                  status_q, status_d;
  logic [CW-1:0]            pos_q, pos_d;

  logic signed [DATA_W-1:0] cell_val  [CAPACITY];
  logic                     cell_lt   [CAPACITY];
  logic                     cell_slt  [CAPACITY];
  logic                     cell_seq  [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_val;
    logic                     left_lt;
    logic                     nxt_lt;
    logic                     nxt_eq;
    logic                     valid;

    assign valid = CW'(i) < count_q;

    if (i == 0) begin : g_head
      assign left_val = value_q;
      assign left_lt  = 1'b1;
    end else begin : g_body
      assign left_val = cell_val[i-1];
      assign left_lt  = cell_lt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign nxt_lt = 1'b0;
      assign nxt_eq = 1'b0;
    end else begin : g_link
      assign nxt_lt = cell_slt[i+1];
      assign nxt_eq = cell_seq[i+1];
    end

    ssi_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .value_i    (value_q),
      .valid_i    (valid),
      .left_val_i (left_val),
      .left_lt_i  (left_lt),
      .scan_lt_i  (nxt_lt),
      .scan_eq_i  (nxt_eq),
      .val_o      (cell_val[i]),
      .lt_o       (cell_lt[i]),
      .scan_lt_o  (cell_slt[i]),
      .scan_eq_o  (cell_seq[i])
    );
  end

  always_comb begin
    state_d    = state_q;
    ctrl       = '0;
    count_d    = count_q;
    k_d        = k_q;
    valid_d    = 1'b0;
    status_d   = status_q;
    pos_d      = pos_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        ctrl.load = 1'b1;
        k_d       = '0;
        state_d   = S_SCAN;
      end
      S_SCAN: begin
        // invalid cells and the tail filler never flag below, so the scan stops
        if (cell_slt[0]) begin
          ctrl.shift = 1'b1;
          k_d        = k_q + 1'b1;
        end else begin
          pos_d = k_q;
          if (cell_seq[0]) begin
            status_d = ST_PRESENT;
            valid_d  = 1'b1;
            state_d  = S_IDLE;
          end else if (count_q == CW'(CAPACITY)) begin
            status_d = ST_FULL;
            valid_d  = 1'b1;
            state_d  = S_IDLE;
          end else begin
            state_d = S_WRITE;
          end
        end
      end
      S_WRITE: begin
        ctrl.write = 1'b1;
        count_d    = count_q + 1'b1;
        status_d   = ST_INSERTED;
        valid_d    = 1'b1;
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      k_q     <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      k_q     <= k_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    pos_q    <= pos_d;
    if (state_q == S_IDLE && start_i) begin
      value_q <= value_i;
    end
  end

  assign busy_o     = (state_q != S_IDLE);
  assign valid_o    = valid_q;
  assign status_o   = status_q;
  assign position_o = FIELD_W'(pos_q);
  assign count_o    = FIELD_W'(count_q);

`ifndef SYNTHESIS
  a_strobe_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("result strobe held longer than one cycle");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("element count above capacity");

  a_count_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && status_o == ST_INSERTED) |-> (count_q == $past(count_q) + 1'b1))
    else $error("insertion without count increment");

  a_full_only_at_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && status_o == ST_FULL) |-> (count_q == CW'(CAPACITY)))
    else $error("full status below capacity");

  a_pos_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && status_o == ST_PRESENT) |-> (pos_q < count_q))
    else $error("present entry position outside stored range");
`endif

endmodule

// File: test/sorted_set_insert_top_test.sv
`timescale 1ns / 100ps
// self-checking testbench for the sorted set insert block: directed table then random inserts
module sorted_set_insert_top_test import ssi_pkg::*; ();

  localparam int unsigned CAPACITY   = DEFAULT_CAPACITY;
  localparam int          N_DIRECTED = 16;
  localparam int          N_RANDOM   = 1134;
  localparam int          N_FILL     = 600;   // random items with many fresh values
  localparam int          N_NO_GAP   = 200;   // closing items sent back to back
  localparam int          DRAIN_WAIT = 80;    // wait after the last result before the verdict

  typedef struct packed {
    status_e            status;
    logic [FIELD_W-1:0] position;
    logic [FIELD_W-1:0] count;
  } insert_result_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     fixed_exp;
    insert_result_t           want;
  } stim_row_t;

  logic                     clk_i   = 1'b0;
  logic                     rst_ni  = 1'b0;
  logic                     start_i = 1'b0;
  logic signed [DATA_W-1:0] value_i = '0;
  logic                     busy_o;
  logic                     valid_o;
  logic [STATUS_W-1:0]      status_o;
  logic [FIELD_W-1:0]       position_o;
  logic [FIELD_W-1:0]       count_o;

  logic signed [DATA_W-1:0] shadow_set [CAPACITY];
  int unsigned              shadow_count = 0;
  insert_result_t           pending_results [$];
  int unsigned              error_count = 0;
  stim_row_t                directed_rows [N_DIRECTED];

  sorted_set_insert_top #(.CAPACITY(CAPACITY)) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .value_i   (value_i),
    .busy_o    (busy_o),
    .valid_o   (valid_o),
    .status_o  (status_o),
    .position_o(position_o),
    .count_o   (count_o)
  );

  always #1 clk_i = ~clk_i;

  // sorted insert with dedup on the shadow copy of the set
  function automatic insert_result_t predict_insert(logic signed [DATA_W-1:0] v);
    insert_result_t r;
    int unsigned    pos;
    bit             found;
    pos   = shadow_count;
    found = 1'b0;
    for (int unsigned i = 0; i < shadow_count; i++) begin
      if (shadow_set[i] == v) begin
        found = 1'b1;
        pos   = i;
        break;
      end
      if (v < shadow_set[i]) begin
        pos = i;
        break;
      end
    end
    if (found) begin
      r.status = ST_PRESENT;
    end else if (shadow_count >= CAPACITY) begin
      r.status = ST_FULL;
    end else begin
      for (int unsigned i = shadow_count; i > pos; i--) shadow_set[i] = shadow_set[i-1];
      shadow_set[pos] = v;
      shadow_count++;
      r.status = ST_INSERTED;
    end
    r.position = pos[FIELD_W-1:0];
    r.count    = shadow_count[FIELD_W-1:0];
    return r;
  endfunction

  // mostly values already held or next to held ones, so duplicates and tight slots are common
  function automatic logic signed [DATA_W-1:0] pick_value(bit filling);
    int unsigned              sel;
    logic signed [DATA_W-1:0] v;
    sel = $urandom_range(0, 99);
    if (shadow_count == 0 || sel < (filling ? 25 : 15)) begin
      v = $urandom;
    end else if (sel < 32) begin
      v = shadow_set[$urandom_range(0, shadow_count - 1)] + ($urandom_range(0, 1) ? 1 : -1);
    end else if (sel < 38) begin
      case ($urandom_range(0, 2))
        0:       v = {1'b0, {(DATA_W-1){1'b1}}};
        1:       v = {1'b1, {(DATA_W-1){1'b0}}};
        default: v = $signed($urandom_range(0, 40)) - 20;
      endcase
    end else begin
      v = shadow_set[$urandom_range(0, shadow_count - 1)];
    end
    return v;
  endfunction

  // holds start until the transfer, then queues what the result must be
  task automatic send_value(logic signed [DATA_W-1:0] v, bit use_fixed, insert_result_t fixed);
    insert_result_t predicted;
    start_i <= 1'b1;
    value_i <= v;
    do @(posedge clk_i); while (busy_o);
    predicted = predict_insert(v);
    pending_results.push_back(use_fixed ? fixed : predicted);
  endtask

  task automatic maybe_gap();
    if ($urandom_range(0, 3) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
  endtask

  always @(posedge clk_i) begin
    insert_result_t got;
    insert_result_t want;
    if (rst_ni && valid_o) begin
      got = '{status_e'(status_o), position_o, count_o};
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result status %0d position %0d count %0d",
                 $time, got.status, got.position, got.count);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
          error_count++;
        end
        if (got.position !== want.position) begin
          $display("%0t: position expected %0d actual %0d", $time, want.position, got.position);
          error_count++;
        end
        if (got.count !== want.count) begin
          $display("%0t: count expected %0d actual %0d", $time, want.count, got.count);
          error_count++;
        end
      end
    end
  end

  initial begin
    directed_rows = '{
      '{32'sd0,          1'b1, '{ST_INSERTED, 7'd0, 7'd1}},
      '{32'sd0,          1'b1, '{ST_PRESENT,  7'd0, 7'd1}},
      '{32'sh80000000,   1'b1, '{ST_INSERTED, 7'd0, 7'd2}},  // most negative goes to the head
      '{32'sh7FFFFFFF,   1'b1, '{ST_INSERTED, 7'd2, 7'd3}},  // beyond the tail: position is count
      '{32'sh7FFFFFFF,   1'b1, '{ST_PRESENT,  7'd2, 7'd3}},
      '{32'sh80000000,   1'b1, '{ST_PRESENT,  7'd0, 7'd3}},
      '{32'shFFFFFFFF,   1'b0, '0},
      '{32'sd1,          1'b0, '0},
      '{32'sh7FFFFFFE,   1'b0, '0},
      '{32'sh80000001,   1'b0, '0},
      '{32'sh55555555,   1'b0, '0},
      '{32'shAAAAAAAA,   1'b0, '0},
      '{32'shFFFFFFFF,   1'b0, '0},
      '{32'sh00010000,   1'b0, '0},
      '{32'shFFFFFF9C,   1'b0, '0},
      '{32'sd1,          1'b0, '0}
    };
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[k]) begin
      maybe_gap();
      send_value(directed_rows[k].value, directed_rows[k].fixed_exp, directed_rows[k].want);
    end

    for (int k = 0; k < N_RANDOM; k++) begin
      if (k < N_RANDOM - N_NO_GAP) maybe_gap();
      send_value(pick_value(k < N_FILL), 1'b0, '0);
    end
    start_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (error_count == 0) begin
      $display("** sorted_set_insert_top: PASSED **");
    end else begin
      $display("** sorted_set_insert_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("** sorted_set_insert_top: FAILED **");
    $finish;
  end

endmodule

// File: files.f
hdl/ssi_pkg.sv
hdl/ssi_cell.sv
hdl/sorted_set_insert_top.sv
test/sorted_set_insert_top_test.sv
